[hw/rtl/isotp_pkg.sv]
package isotp_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FC   = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_ID    = 3'd1,
    ERR_SF_LEN    = 3'd2,
    ERR_TOO_LARGE = 3'd3,
    ERR_BAD_FF    = 3'd4,
    ERR_ZERO_LEN  = 3'd5,
    ERR_SEQ       = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    CFG_RX_ID    = 3'd0,
    CFG_RX_EXT   = 3'd1,
    CFG_TX_ID    = 3'd2,
    CFG_TX_EXT   = 3'd3,
    CFG_CAPACITY = 3'd4
  } cfg_idx_t;

  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  localparam logic [3:0]  MAX_DLC     = 4'd8;
  localparam logic [3:0]  SF_MAX_LEN  = 4'd7;
  localparam logic [11:0] FF_BYTES    = 12'd6;
  localparam logic [3:0]  SEQ_FIRST   = 4'd1;

  localparam int ID_W  = 29;
  localparam int LEN_W = 12;

  typedef struct packed {
    logic [ID_W-1:0]  rx_id;
    logic             rx_ext;
    logic [LEN_W-1:0] capacity;
  } cfg_t;

  // One accepted frame, reduced to the results it still has to produce
  typedef struct packed {
    logic [6:0][7:0]  payload;
    logic [2:0]       cnt;
    logic [LEN_W-1:0] base;
    logic             fc;
    logic             done;
    logic [LEN_W-1:0] msg_len;
    err_t             err;
  } job_t;

endpackage

[hw/rtl/isotp_front.sv]
module isotp_front
  import isotp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg_i,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [103:0]    in_tdata,
  input  logic            in_tuser,
  input  logic            full_i,
  output logic            push_o,
  output job_t            job_o
);

  logic             recv_r, recv_nxt;
  logic [3:0]       seq_r, seq_nxt;
  logic [LEN_W-1:0] br_r, br_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;

  logic [ID_W-1:0]  frame_id;
  logic [3:0]       dlc, flen, flen_m1;
  logic [7:0][7:0]  d;
  logic [3:0]       pci_type, pci_low;
  logic             match, accept, has_results;
  logic [LEN_W-1:0] remain, br_sum, ff_total;
  logic [2:0]       cf_cnt;
  job_t             job;

  assign frame_id = in_tdata[28:0];
  assign dlc      = in_tdata[32:29];
  assign d        = in_tdata[96:33];
  assign flen     = (dlc > MAX_DLC) ? MAX_DLC : dlc;
  assign flen_m1  = flen - 4'd1;
  assign pci_type = d[0][7:4];
  assign pci_low  = d[0][3:0];
  assign match    = (frame_id == cfg_i.rx_id) && (in_tuser == cfg_i.rx_ext) &&
                    (flen != 4'd0);
  assign ff_total = {pci_low, d[1]};

  assign remain = (br_r < total_r) ? (total_r - br_r) : '0;
  assign cf_cnt = ({8'd0, flen_m1} > remain) ? remain[2:0] : flen_m1[2:0];
  assign br_sum = br_r + {9'd0, cf_cnt};

  assign in_tready = !full_i;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    job         = '0;
    job.err     = ERR_NONE;
    job.payload = d[7:1];
    recv_nxt    = recv_r;
    seq_nxt     = seq_r;
    br_nxt      = br_r;
    total_nxt   = total_r;
    has_results = 1'b1;
    if (recv_r) begin
      if (!match || pci_type != PCI_CF) begin
        has_results = 1'b0;
      end else if (pci_low != seq_r) begin
        job.err = ERR_SEQ;
      end else begin
        job.cnt  = cf_cnt;
        job.base = br_r;
        br_nxt   = br_sum;
        seq_nxt  = seq_r + 4'd1;
        if (br_sum >= total_r) begin
          job.done    = 1'b1;
          job.msg_len = total_r;
          recv_nxt    = 1'b0;
        end
        has_results = (cf_cnt != 3'd0) || (br_sum >= total_r);
      end
    end else if (!match) begin
      job.err = ERR_BAD_ID;
    end else if (pci_type == PCI_SF) begin
      if (pci_low > SF_MAX_LEN || pci_low > flen_m1) begin
        job.err = ERR_SF_LEN;
      end else if (cfg_i.capacity < {8'd0, pci_low}) begin
        job.err = ERR_TOO_LARGE;
      end else begin
        job.cnt     = pci_low[2:0];
        job.done    = 1'b1;
        job.msg_len = {8'd0, pci_low};
      end
    end else if (pci_type != PCI_FF || flen < MAX_DLC) begin
      job.err = ERR_BAD_FF;
    end else if (ff_total == '0) begin
      job.err = ERR_ZERO_LEN;
    end else if (cfg_i.capacity < ff_total) begin
      job.err = ERR_TOO_LARGE;
    end else begin
      job.payload = {8'd0, d[7:2]};
      job.cnt     = (ff_total < FF_BYTES) ? ff_total[2:0] : FF_BYTES[2:0];
      job.fc      = 1'b1;
      if (ff_total <= FF_BYTES) begin
        job.done    = 1'b1;
        job.msg_len = ff_total;
      end else begin
        recv_nxt  = 1'b1;
        seq_nxt   = SEQ_FIRST;
        br_nxt    = FF_BYTES;
        total_nxt = ff_total;
      end
    end
    // any error drops the reception
    if (job.err != ERR_NONE) begin
      recv_nxt  = 1'b0;
      seq_nxt   = SEQ_FIRST;
      br_nxt    = '0;
      total_nxt = '0;
    end else if (job.done) begin
      recv_nxt  = 1'b0;
      seq_nxt   = SEQ_FIRST;
      br_nxt    = '0;
      total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r  <= 1'b0;
      seq_r   <= SEQ_FIRST;
      br_r    <= '0;
      total_r <= '0;
    end else if (accept) begin
      recv_r  <= recv_nxt;
      seq_r   <= seq_nxt;
      br_r    <= br_nxt;
      total_r <= total_nxt;
    end
  end

  assign push_o = accept && has_results;
  assign job_o  = job;

  a_recv_short: assert property (@(posedge clk) disable iff (!rst_n)
    recv_r |-> (br_r < total_r))
    else $error("receiving with no bytes outstanding");

endmodule

[hw/rtl/isotp_fifo.sv]
module isotp_fifo
  import isotp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wr_ptr_r] <= job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop_i) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + CW'(1);
      end else if (pop_i && !push_i) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign full_o  = (count_r == CW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = mem[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (count_r < CW'(DEPTH)))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (count_r != '0))
    else $error("queue underflow");

endmodule

[hw/rtl/isotp_back.sv]
module isotp_back
  import isotp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         empty_i,
  input  job_t         head_i,
  output logic         pop_o,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  logic [2:0]       step_r;
  logic             out_valid_r;
  kind_t            kind_r;
  logic [7:0]       data_r;
  logic [LEN_W-1:0] off_r, len_r;
  err_t             err_r;
  logic             last_r;

  logic             emit, is_last;
  logic [3:0]       n_res;
  kind_t            kind_c;
  logic [7:0]       data_c;
  logic [LEN_W-1:0] off_c, len_c;
  err_t             err_c;

  assign n_res = {1'b0, head_i.cnt} + {3'd0, head_i.fc} + {3'd0, head_i.done};

  always_comb begin
    kind_c  = KIND_DONE;
    data_c  = '0;
    off_c   = '0;
    len_c   = '0;
    err_c   = ERR_NONE;
    is_last = ({1'b0, step_r} == n_res - 4'd1);
    if (head_i.err != ERR_NONE) begin
      kind_c  = KIND_ERR;
      err_c   = head_i.err;
      is_last = 1'b1;
    end else if (step_r < head_i.cnt) begin
      kind_c = KIND_DATA;
      data_c = head_i.payload[step_r];
      off_c  = head_i.base + {9'd0, step_r};
    end else if (step_r == head_i.cnt && head_i.fc) begin
      kind_c = KIND_FC;
    end else begin
      len_c = head_i.msg_len;
    end
  end

  assign emit  = !empty_i && (!out_valid_r || out_tready);
  assign pop_o = emit && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        step_r <= is_last ? 3'd0 : step_r + 3'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind_c;
      data_r <= data_c;
      off_r  <= off_c;
      len_r  <= len_c;
      err_r  <= err_c;
      last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {5'd0, err_r, len_r, off_r, data_r};

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty_i && head_i.err == ERR_NONE) |-> ({1'b0, step_r} < n_res))
    else $error("result step past end of job");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_ERR) |-> last_r)
    else $error("error result not marked last");

endmodule

[hw/rtl/iso_tp_reassembler_top.sv]
// ISO-TP receive reassembler.
// in_*: one received CAN frame per request. in_tdata from bit 0: frame_id[28:0],
//   frame_length[32:29], byte0..byte7[96:33], zero fill; in_tuser: frame_extended.
// out_*: one result per request. out_tuser: kind (payload byte, send flow
//   control, message complete, error); out_tlast marks the last result of a
//   frame. out_tdata from bit 0: data_byte, byte_offset, message_length,
//   error_code, zero fill.
// cfg_*: register writes (rx_id, rx_extended, tx_id, tx_extended,
//   buffer_capacity) while no request is in flight; they apply at once, also to
//   a reception in progress. tx_id and tx_extended have no effect on results
//   and are not stored.
// The front classifies a frame in the cycle it is accepted and queues a job of
// up to eight results; the back sends one result per cycle from an output
// register while the receiver is ready. out_tvalid rises after a job has
// passed the job queue and the output register. A frame yields 0 to 8 results;
// frames are accepted back to back until the job queue of QUEUE_DEPTH entries fills.
// A stalled receiver holds the output register and then backs up the queue.
// Reset clears the queue, the output register and the reception state and
// returns the registers to their reset values (buffer_capacity 4095).
module iso_tp_reassembler_top
  import isotp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [103:0]  in_tdata,   // frame_id, frame_length, byte0..byte7
  input  logic          in_tuser,   // frame_extended
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [39:0]   out_tdata,  // data_byte, byte_offset, message_length, error_code
  output logic [1:0]    out_tuser,  // kind
  output logic          out_tlast,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [28:0]   cfg_wdata
);

  cfg_t cfg_r;
  logic push, pop, full, empty;
  job_t job_in, job_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rx_id    <= '0;
      cfg_r.rx_ext   <= 1'b0;
      cfg_r.capacity <= 12'd4095;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RX_ID:    cfg_r.rx_id    <= cfg_wdata;
        CFG_RX_EXT:   cfg_r.rx_ext   <= cfg_wdata[0];
        CFG_CAPACITY: cfg_r.capacity <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  isotp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .full_i    (full),
    .push_o    (push),
    .job_o     (job_in)
  );

  isotp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (job_head)
  );

  isotp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty_i    (empty),
    .head_i     (job_head),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
